>>> hw/rtl/rpc_pkg.sv
package rpc_pkg;

	localparam int RP_LENGTH = 55;
	localparam int STRIDE    = 7;
	localparam int DIGITS    = 6;
	localparam int COUNT_MAX = 63;

	localparam logic [7:0]  ASCII_ZERO  = 8'd48;
	localparam logic [7:0]  ASCII_NINE  = 8'd57;
	localparam logic [19:0] GROUP_LIMIT = 20'd720896;

	// Exact quotient by eleven for any 20-bit value: (v * 1525202) >> 24.
	localparam logic [20:0] DIV11_RECIP = 21'd1525202;
	localparam int          DIV11_SHIFT = 24;
	localparam int          PROD_W      = 41;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_WRONG_LEN = 3'd1;
	localparam logic [2:0] ST_NONDIGIT  = 3'd2;
	localparam logic [2:0] ST_NOT_MULT  = 3'd3;
	localparam logic [2:0] ST_TOO_LARGE = 3'd4;
	localparam logic [2:0] ST_BAD_CHECK = 3'd5;

	typedef struct packed {
		logic        has_group;
		logic [2:0]  gidx;
		logic [19:0] value;
		logic        nondig;
		logic        resid_ok;
		logic        is_last;
		logic        len_ok;
	} rpc_entry_t;

endpackage

>>> hw/rtl/rpc_front.sv
module rpc_front import rpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_code,
	input  logic       is_last,
	input  logic       q_full,
	output logic       push,
	output rpc_entry_t push_entry
);

	logic [5:0]  count_q;
	logic [2:0]  dpos_q;
	logic [2:0]  gidx_q;
	logic [19:0] value_q;
	logic [3:0]  resid_q;
	logic        nondig_q;

	logic        accept;
	logic        in_body;
	logic        digit_pos;
	logic        group_end;
	logic        is_dig;
	logic [3:0]  dig;
	logic [19:0] value_next;
	logic [4:0]  resid_raw;
	logic [3:0]  resid_next;
	logic [5:0]  count_next;

	assign char_stall = q_full;
	assign accept     = char_valid && !q_full;

	always_comb begin
		in_body    = count_q < 6'(RP_LENGTH);
		digit_pos  = in_body && (dpos_q < 3'(DIGITS));
		group_end  = digit_pos && (dpos_q == 3'(DIGITS - 1));
		is_dig     = (char_code >= ASCII_ZERO) && (char_code <= ASCII_NINE);
		dig        = is_dig ? 4'(char_code - ASCII_ZERO) : 4'd0;
		value_next = (value_q << 3) + (value_q << 1) + 20'(dig);
		if (dpos_q[0] == 1'b0) begin
			resid_raw = {1'b0, resid_q} + {1'b0, dig};
		end else begin
			resid_raw = {1'b0, resid_q} + 5'd11 - {1'b0, dig};
		end
		resid_next = (resid_raw >= 5'd11) ? 4'(resid_raw - 5'd11) : resid_raw[3:0];
		count_next = (count_q == 6'(COUNT_MAX)) ? count_q : count_q + 6'd1;
	end

	assign push = accept && (group_end || is_last);

	always_comb begin
		push_entry.has_group = group_end;
		push_entry.gidx      = gidx_q;
		push_entry.value     = value_next;
		push_entry.nondig    = nondig_q || !is_dig;
		push_entry.resid_ok  = (resid_q == dig);
		push_entry.is_last   = is_last;
		push_entry.len_ok    = (count_next == 6'(RP_LENGTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			dpos_q   <= '0;
			gidx_q   <= '0;
			value_q  <= '0;
			resid_q  <= '0;
			nondig_q <= 1'b0;
		end else if (accept) begin
			if (is_last) begin
				count_q  <= '0;
				dpos_q   <= '0;
				gidx_q   <= '0;
				value_q  <= '0;
				resid_q  <= '0;
				nondig_q <= 1'b0;
			end else begin
				count_q <= count_next;
				if (in_body) begin
					if (dpos_q == 3'(STRIDE - 1)) begin
						dpos_q <= '0;
						gidx_q <= gidx_q + 3'd1;
					end else begin
						dpos_q <= dpos_q + 3'd1;
					end
				end
				if (group_end) begin
					value_q  <= '0;
					resid_q  <= '0;
					nondig_q <= 1'b0;
				end else if (digit_pos) begin
					value_q  <= value_next;
					resid_q  <= resid_next;
					nondig_q <= nondig_q || !is_dig;
				end
			end
		end
	end

endmodule

>>> hw/rtl/rpc_queue.sv
module rpc_queue import rpc_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  rpc_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output rpc_entry_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rpc_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> hw/rtl/rpc_back.sv
module rpc_back import rpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  rpc_entry_t  q_head,
	output logic        pop,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        is_final,
	output logic [2:0]  group_index,
	output logic [15:0] group_word,
	output logic [2:0]  status
);

	logic              valid_s1;
	rpc_entry_t        entry_s1;
	logic [PROD_W-1:0] prod_s1;

	logic              valid_s2;
	logic              has_group_s2;
	logic [2:0]        gidx_s2;
	logic [15:0]       word_s2;
	logic [2:0]        st_s2;
	logic              last_s2;
	logic              len_ok_s2;
	logic              grp_done_s2;

	logic [2:0]        first_error_q;
	logic              out_valid_q;
	logic              out_final_q;
	logic [2:0]        out_gidx_q;
	logic [15:0]       out_word_q;
	logic [2:0]        out_st_q;

	logic [16:0]       quot;
	logic [20:0]       quot_x11;
	logic [2:0]        st_calc;
	logic              out_free;
	logic              emit;
	logic              emit_group;
	logic              retire_s2;
	logic              load_s2;

	always_comb begin
		quot     = prod_s1[PROD_W-1:DIV11_SHIFT];
		quot_x11 = 21'({quot, 3'b000}) + 21'({quot, 1'b0}) + 21'(quot);
		if (entry_s1.nondig) begin
			st_calc = ST_NONDIGIT;
		end else if (quot_x11 != {1'b0, entry_s1.value}) begin
			st_calc = ST_NOT_MULT;
		end else if (entry_s1.value >= GROUP_LIMIT) begin
			st_calc = ST_TOO_LARGE;
		end else if (!entry_s1.resid_ok) begin
			st_calc = ST_BAD_CHECK;
		end else begin
			st_calc = ST_OK;
		end
	end

	assign out_free   = !out_valid_q || !result_stall;
	assign emit       = valid_s2 && out_free;
	assign emit_group = has_group_s2 && !grp_done_s2;
	assign retire_s2  = emit && !(emit_group && last_s2);
	assign load_s2    = valid_s1 && (!valid_s2 || retire_s2);
	assign pop        = !q_empty && (!valid_s1 || load_s2);

	always_ff @(posedge clk) begin
		if (pop) begin
			entry_s1 <= q_head;
			prod_s1  <= {21'd0, q_head.value} * {20'd0, DIV11_RECIP};
		end
		if (load_s2) begin
			has_group_s2 <= entry_s1.has_group;
			gidx_s2      <= entry_s1.gidx;
			word_s2      <= (st_calc == ST_OK) ? quot[15:0] : 16'd0;
			st_s2        <= st_calc;
			last_s2      <= entry_s1.is_last;
			len_ok_s2    <= entry_s1.len_ok;
		end
		if (emit) begin
			out_final_q <= !emit_group;
			out_gidx_q  <= emit_group ? gidx_s2 : 3'd0;
			out_word_q  <= emit_group ? word_s2 : 16'd0;
			if (emit_group) begin
				out_st_q <= st_s2;
			end else begin
				out_st_q <= len_ok_s2 ? first_error_q : ST_WRONG_LEN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			grp_done_s2   <= 1'b0;
			first_error_q <= ST_OK;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2    <= 1'b1;
				grp_done_s2 <= 1'b0;
			end else if (retire_s2) begin
				valid_s2 <= 1'b0;
			end else if (emit && emit_group) begin
				grp_done_s2 <= 1'b1;
			end
			if (emit) begin
				if (emit_group) begin
					if (st_s2 != ST_OK && first_error_q == ST_OK) begin
						first_error_q <= st_s2;
					end
				end else begin
					first_error_q <= ST_OK;
				end
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign is_final     = out_final_q;
	assign group_index  = out_gidx_q;
	assign group_word   = out_word_q;
	assign status       = out_st_q;

endmodule

>>> hw/rtl/recovery_password_checker_unit.sv
// Channel   Direction  Handshake                  Payload
// char      in         char_valid / char_stall    char_code, is_last
// result    out        result_valid / result_stall is_final, group_index, group_word, status
//
// One character is taken each cycle while char_stall is low; the front end parses it in that same cycle.
// A group or overall result passes through the request queue, the divide-by-eleven
// multiplier stage, the status stage and the output register.
// A closing character that also ends a group gives two results, the group result first and then the overall result.
// char_stall rises only while the request queue holds QUEUE_DEPTH entries.
// Reset clears all parse state, the first error and every valid flag at once.
module recovery_password_checker_unit import rpc_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	input  logic        is_last,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        is_final,
	output logic [2:0]  group_index,
	output logic [15:0] group_word,
	output logic [2:0]  status
);

	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;
	rpc_entry_t push_entry;
	rpc_entry_t q_head;

	rpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.is_last    (is_last),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	rpc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.empty      (q_empty),
		.head       (q_head)
	);

	rpc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.is_final     (is_final),
		.group_index  (group_index),
		.group_word   (group_word),
		.status       (status)
	);

`ifndef SYNTHESIS
	a_final_clean : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_final |-> group_index == 3'd0 && group_word == 16'd0)
		else $error("overall result carries group data");

	a_failed_word_zero : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !is_final && status != ST_OK |-> group_word == 16'd0)
		else $error("failed group reports a nonzero word");

	a_group_status : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !is_final |-> status != ST_WRONG_LEN && status <= ST_BAD_CHECK)
		else $error("group result with an impossible status");

	a_pop_nonempty : assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("request taken from an empty queue");
`endif

endmodule
